@@ rtl/core/sst_pkg.sv @@
// sst_pkg: shared types, sizes and codes for the sprite slot table
// used by sst_free_find, sprite_slot_table and sst_checker, depends on nothing
package sst_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int GRP    = 8;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = (SLOTS + GRP - 1) / GRP;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD    = NGRP * GRP;

  localparam logic [31:0] SCALE_ONE = 32'h3F80_0000;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_SET_POS   = 3'd2,
    OP_SET_SCALE = 3'd3,
    OP_GET       = 3'd4,
    OP_COUNT     = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ID  = 2'd1,
    ST_NEG_TEX = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] slot_id;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        scale_word;
    logic signed [15:0] texture_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  result_slot;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_scale;
    logic [14:0] out_texture;
    logic [6:0]  used_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] scale;
    logic [14:0] texture;
  } slot_entry_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

endpackage

@@ rtl/core/sst_ram.sv @@
// sst_ram: generic single-write, single-read memory with registered read
// no dependencies
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/sst_free_find.sv @@
// sst_free_find: registered search for the lowest dead slot below the count
// depends on sst_pkg
module sst_free_find (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sst_pkg::SLOTS-1:0] live,
  input  logic [sst_pkg::CNT_W-1:0] count,
  output sst_pkg::free_t            free_r
);

  logic [sst_pkg::PAD-1:0]   free_v;
  logic [sst_pkg::NGRP-1:0]  grp_any;
  logic [sst_pkg::GRP_W-1:0] grp_idx [sst_pkg::NGRP];
  logic [sst_pkg::GSEL_W-1:0] sel;
  logic                      any;
  sst_pkg::free_t            free_nxt;

  for (genvar g = 0; g < sst_pkg::PAD; g++) begin : g_mask
    if (g < sst_pkg::SLOTS) begin : g_real
      assign free_v[g] = !live[g] && (sst_pkg::CNT_W'(g) < count);
    end else begin : g_pad
      assign free_v[g] = 1'b0;
    end
  end

  always_comb begin
    for (int g = 0; g < sst_pkg::NGRP; g++) begin
      grp_any[g] = |free_v[g*sst_pkg::GRP +: sst_pkg::GRP];
      grp_idx[g] = '0;
      for (int b = sst_pkg::GRP - 1; b >= 0; b--) begin
        if (free_v[g*sst_pkg::GRP + b]) begin
          grp_idx[g] = sst_pkg::GRP_W'(b);
        end
      end
    end
  end

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int g = sst_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel = sst_pkg::GSEL_W'(g);
        any = 1'b1;
      end
    end
    free_nxt.found = any;
    free_nxt.idx   = sst_pkg::IDX_W'({sel, grp_idx[sel]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
    end else begin
      free_r <= free_nxt;
    end
  end

endmodule

@@ rtl/core/sprite_slot_table.sv @@
// sprite_slot_table: slot allocator with tombstones over one slot memory
// the input word and slot read are registered, then the result word; held while out stalls
// takes one word at a time, the next only after the last result is loaded to out
// synchronous reset clears live marks and the count; slot memory is not cleared
// depends on sst_pkg, sst_ram, sst_free_find
module sprite_slot_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sst_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sst_pkg::out_word_t  out_word
);

  localparam int EW = $bits(sst_pkg::slot_entry_t);

  sst_pkg::state_t           state_r, state_nxt;
  sst_pkg::in_word_t         req_r;
  logic [sst_pkg::SLOTS-1:0] live_r, live_nxt;
  logic [sst_pkg::CNT_W-1:0] hw_r, hw_nxt;
  sst_pkg::out_word_t        res, res_r, out_word_r;
  logic                      out_valid_r;
  sst_pkg::free_t            free_r;
  sst_pkg::slot_entry_t      rd_entry, wr_entry;
  logic [EW-1:0]             rd_data;
  logic [sst_pkg::IDX_W-1:0] wr_addr, id_idx;
  logic                      wr_req, wr_en;
  logic [15:0]               id_u;
  logic                      id_ok;
  logic                      out_free, accept, commit, load_out;

  sst_ram #(
    .WIDTH (EW),
    .DEPTH (sst_pkg::SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (in_word.slot_id[sst_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  sst_free_find u_free_find (
    .clk    (clk),
    .rst_n  (rst_n),
    .live   (live_r),
    .count  (hw_r),
    .free_r (free_r)
  );

  assign rd_entry = rd_data;
  assign id_u     = req_r.slot_id;
  assign id_idx   = id_u[sst_pkg::IDX_W-1:0];
  assign id_ok    = !id_u[15] && (id_u < 16'(hw_r)) && live_r[id_idx];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sst_pkg::S_IDLE: if (in_valid) state_nxt = sst_pkg::S_EXEC;
      sst_pkg::S_EXEC: state_nxt = out_free ? sst_pkg::S_IDLE : sst_pkg::S_WAIT;
      sst_pkg::S_WAIT: if (out_free) state_nxt = sst_pkg::S_IDLE;
      default:         state_nxt = sst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      sst_pkg::S_IDLE: in_stall = 1'b0;
      sst_pkg::S_EXEC: begin
        commit   = 1'b1;
        load_out = out_free;
      end
      sst_pkg::S_WAIT: load_out = out_free;
      default:         in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign wr_en  = commit && wr_req;

  always_comb begin
    res      = '0;
    wr_req   = 1'b0;
    wr_addr  = id_idx;
    wr_entry = rd_entry;
    live_nxt = live_r;
    hw_nxt   = hw_r;
    case (req_r.operation)
      sst_pkg::OP_ADD: begin
        if (req_r.texture_id[15]) begin
          res.status = sst_pkg::ST_NEG_TEX;
        end else if (free_r.found || (hw_r != sst_pkg::CNT_W'(sst_pkg::SLOTS))) begin
          if (free_r.found) begin
            wr_addr = free_r.idx;
          end else begin
            wr_addr = hw_r[sst_pkg::IDX_W-1:0];
            hw_nxt  = hw_r + 1'b1;
          end
          wr_req           = 1'b1;
          wr_entry.x       = req_r.pos_x;
          wr_entry.y       = req_r.pos_y;
          wr_entry.scale   = sst_pkg::SCALE_ONE;
          wr_entry.texture = req_r.texture_id[14:0];
          live_nxt[wr_addr] = 1'b1;
          res.result_slot  = 6'(wr_addr);
        end else begin
          res.status = sst_pkg::ST_FULL;
        end
      end
      sst_pkg::OP_REMOVE: begin
        if (id_ok) live_nxt[id_idx] = 1'b0;
        else res.status = sst_pkg::ST_BAD_ID;
      end
      sst_pkg::OP_SET_POS: begin
        if (id_ok) begin
          wr_req     = 1'b1;
          wr_entry.x = req_r.pos_x;
          wr_entry.y = req_r.pos_y;
        end else begin
          res.status = sst_pkg::ST_BAD_ID;
        end
      end
      sst_pkg::OP_SET_SCALE: begin
        if (id_ok) begin
          wr_req         = 1'b1;
          wr_entry.scale = req_r.scale_word;
        end else begin
          res.status = sst_pkg::ST_BAD_ID;
        end
      end
      sst_pkg::OP_GET: begin
        if (id_ok) begin
          res.out_x       = rd_entry.x;
          res.out_y       = rd_entry.y;
          res.out_scale   = rd_entry.scale;
          res.out_texture = rd_entry.texture;
        end else begin
          res.status = sst_pkg::ST_BAD_ID;
        end
      end
      sst_pkg::OP_CLEAR: begin
        live_nxt = '0;
        hw_nxt   = '0;
      end
      default: res.status = sst_pkg::ST_OK;
    endcase
    res.used_count = 7'(hw_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sst_pkg::S_IDLE;
      live_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (commit) begin
        live_r <= live_nxt;
        hw_r   <= hw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_word;
    if (commit) res_r <= res;
    if (load_out) out_word_r <= commit ? res : res_r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/core/sst_checker.sv @@
// sst_checker: port-level checks on the sprite slot table
// depends on sst_pkg; bound to sprite_slot_table
module sst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sst_pkg::out_word_t out_word
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled out word changed");

  // one word in flight: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // only a successful add reports a slot; a failed word has zero slot, x and texture
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != sst_pkg::ST_OK) |->
      (out_word.result_slot == 6'd0) && (out_word.out_x == 32'd0) &&
      (out_word.out_texture == 15'd0))
    else $error("failed word carries data");

  // count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sst_pkg::SLOTS > 127) ||
      (32'(out_word.used_count) <= sst_pkg::SLOTS))
    else $error("count above table depth");

endmodule

bind sprite_slot_table sst_checker u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

@@ test/sprite_slot_table_test.sv @@
// sprite_slot_table_test: self-checking bench for the sprite slot table
// keeps its own copy of the slot table and compares every result word
// depends on sst_pkg and sprite_slot_table
`timescale 1ns / 1ps

module sprite_slot_table_test;
  import sst_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  logic [31:0] mirror_x     [SLOTS];
  logic [31:0] mirror_y     [SLOTS];
  logic [31:0] mirror_scale [SLOTS];
  logic [14:0] mirror_tex   [SLOTS];
  logic        mirror_live  [SLOTS];
  int          fill_level;

  out_word_t pending_results[$];
  out_word_t want;
  int        errors;
  int        gap_pct;
  int        stall_pct;
  int        stall_left;
  int        hold_left;

  sprite_slot_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic out_word_t table_apply(in_word_t w);
    out_word_t r;
    int        idx;
    int        i;
    r = '0;
    idx = -1;
    if (!w.slot_id[15] && int'(w.slot_id[14:0]) < fill_level && mirror_live[w.slot_id[5:0]])
      idx = int'(w.slot_id[14:0]);
    case (w.operation)
      OP_ADD: begin
        if (w.texture_id[15]) begin
          r.status = ST_NEG_TEX;
        end else begin
          i = 0;
          while (i < fill_level && mirror_live[i]) i++;
          if (i == fill_level && fill_level == SLOTS) begin
            r.status = ST_FULL;
          end else begin
            if (i == fill_level) fill_level++;
            mirror_x[i] = w.pos_x;
            mirror_y[i] = w.pos_y;
            mirror_scale[i] = SCALE_ONE;
            mirror_tex[i] = w.texture_id[14:0];
            mirror_live[i] = 1'b1;
            r.result_slot = i[5:0];
          end
        end
      end
      OP_REMOVE: begin
        if (idx < 0) r.status = ST_BAD_ID;
        else mirror_live[idx] = 1'b0;
      end
      OP_SET_POS: begin
        if (idx < 0) begin
          r.status = ST_BAD_ID;
        end else begin
          mirror_x[idx] = w.pos_x;
          mirror_y[idx] = w.pos_y;
        end
      end
      OP_SET_SCALE: begin
        if (idx < 0) r.status = ST_BAD_ID;
        else mirror_scale[idx] = w.scale_word;
      end
      OP_GET: begin
        if (idx < 0) begin
          r.status = ST_BAD_ID;
        end else begin
          r.out_x = mirror_x[idx];
          r.out_y = mirror_y[idx];
          r.out_scale = mirror_scale[idx];
          r.out_texture = mirror_tex[idx];
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < SLOTS; k++) mirror_live[k] = 1'b0;
        fill_level = 0;
      end
      default: ;
    endcase
    r.used_count = fill_level[6:0];
    return r;
  endfunction

  function automatic in_word_t mk(logic [2:0] op, int id, logic [31:0] x, logic [31:0] y,
                                  logic [31:0] sc, int tex);
    in_word_t w;
    w.operation = op;
    w.slot_id = id[15:0];
    w.pos_x = x;
    w.pos_y = y;
    w.scale_word = sc;
    w.texture_id = tex[15:0];
    return w;
  endfunction

  function automatic int pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, fill_level + 1);
    if (r < 90) return $urandom_range(0, 127);
    return $urandom & 32'hFFFF;
  endfunction

  function automatic int pick_tex();
    if ($urandom_range(0, 9) == 0) return $urandom_range(32768, 65535);
    return $urandom_range(0, 32767);
  endfunction

  function automatic in_word_t random_word(logic [2:0] op);
    return mk(op, pick_id(), $urandom, $urandom, $urandom, pick_tex());
  endfunction

  function automatic int next_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_word(in_word_t w, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_apply(w));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endfunction

  // receiver side: random stalls plus a counted hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, got %h", $time, out_word);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_word.status);
        check_field("result_slot", want.result_slot, out_word.result_slot);
        check_field("out_x", want.out_x, out_word.out_x);
        check_field("out_y", want.out_y, out_word.out_y);
        check_field("out_scale", want.out_scale, out_word.out_scale);
        check_field("out_texture", want.out_texture, out_word.out_texture);
        check_field("used_count", want.used_count, out_word.used_count);
      end
    end
  end

  task automatic test_empty_table();
    send_word(mk(OP_GET, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_REMOVE, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_SET_POS, 0, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0), next_gap());
    send_word(mk(OP_SET_SCALE, 0, 0, 0, 32'h4000_0000, 0), next_gap());
    send_word(mk(OP_COUNT, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_UNUSED, 5, $urandom, $urandom, $urandom, 7), next_gap());
    send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0), next_gap());
  endtask

  task automatic test_add_get();
    send_word(mk(OP_ADD, 0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32767), next_gap());
    send_word(mk(OP_ADD, -1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), next_gap());
    send_word(mk(OP_ADD, 0, 32'h1, 32'h2, 32'h3, -1), next_gap());
    send_word(mk(OP_ADD, 0, 32'h1, 32'h2, 32'h3, -32768), next_gap());
    send_word(mk(OP_GET, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, 1, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_SET_SCALE, 1, 0, 0, 32'hFFFF_FFFF, 0), next_gap());
    send_word(mk(OP_SET_POS, 0, 32'h8000_0000, 32'h7F80_0000, 0, 0), next_gap());
    send_word(mk(OP_GET, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, 1, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_REMOVE, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_REMOVE, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_SET_POS, 0, 32'h5, 32'h6, 0, 0), next_gap());
    send_word(mk(OP_SET_SCALE, 0, 0, 0, 32'h7, 0), next_gap());
    send_word(mk(OP_ADD, 0, 32'hC0DE_0001, 32'hC0DE_0002, 0, 12345), next_gap());
    send_word(mk(OP_COUNT, 0, 0, 0, 0, 0), next_gap());
  endtask

  task automatic test_bad_ids();
    send_word(mk(OP_GET, -1, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, -32768, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_REMOVE, 32767, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, 2, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_SET_SCALE, SLOTS, 0, 0, 32'h1, 0), next_gap());
    send_word(mk(OP_SET_POS, 16'h4000, 32'h1, 32'h1, 0, 0), next_gap());
  endtask

  task automatic test_full_table();
    send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0), next_gap());
    repeat (SLOTS) send_word(mk(OP_ADD, 0, $urandom, $urandom, $urandom,
                                $urandom_range(0, 32767)), next_gap());
    send_word(mk(OP_ADD, 0, $urandom, $urandom, 0, 1), next_gap());
    send_word(mk(OP_GET, SLOTS - 1, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, SLOTS, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_REMOVE, 10, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_REMOVE, SLOTS - 1, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_ADD, 0, $urandom, $urandom, 0, 2), next_gap());
    send_word(mk(OP_ADD, 0, $urandom, $urandom, 0, 3), next_gap());
    send_word(mk(OP_ADD, 0, $urandom, $urandom, 0, 4), next_gap());
    send_word(mk(OP_GET, SLOTS - 1, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_COUNT, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_CLEAR, 0, 0, 0, 0, 0), next_gap());
    send_word(mk(OP_GET, 0, 0, 0, 0, 0), next_gap());
  endtask

  task automatic test_backpressure();
    int saved_gap;
    int saved_stall;
    saved_gap = gap_pct;
    saved_stall = stall_pct;
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 150;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_word(random_word(OP_ADD), 0);
      else send_word(random_word(OP_GET), 0);
    end
    drain();
    gap_pct = saved_gap;
    stall_pct = saved_stall;
  endtask

  task automatic test_random_mix();
    int        r;
    logic [2:0] op;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = phase * 25;
      stall_pct = phase * 20;
      repeat (100) begin
        r = $urandom_range(0, 99);
        if (r < 33) op = OP_ADD;
        else if (r < 46) op = OP_REMOVE;
        else if (r < 58) op = OP_SET_POS;
        else if (r < 70) op = OP_SET_SCALE;
        else if (r < 92) op = OP_GET;
        else if (r < 96) op = OP_COUNT;
        else if (r < 98) op = OP_CLEAR;
        else op = OP_UNUSED;
        send_word(random_word(op), next_gap());
      end
      drain();
    end
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    errors = 0;
    fill_level = 0;
    gap_pct = 20;
    stall_pct = 15;
    stall_left = 0;
    hold_left = 0;
    for (int k = 0; k < SLOTS; k++) begin
      mirror_x[k] = '0;
      mirror_y[k] = '0;
      mirror_scale[k] = '0;
      mirror_tex[k] = '0;
      mirror_live[k] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_get();
    test_bad_ids();
    drain();
    test_full_table();
    drain();
    test_backpressure();
    test_random_mix();

    repeat (10) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sst_pkg.sv
rtl/core/sst_ram.sv
rtl/core/sst_free_find.sv
rtl/core/sprite_slot_table.sv
rtl/core/sst_checker.sv
test/sprite_slot_table_test.sv
